// File: rtl/square_sine_tone_generator_defines.svh
// Assertion helpers shared by the tone generator RTL.
`ifndef SQUARE_SINE_TONE_GENERATOR_DEFINES_SVH
`define SQUARE_SINE_TONE_GENERATOR_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SSTG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("sstg assertion failed");

// Check a property on every clock edge, reset included.
`define SSTG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sstg assertion failed");

`endif

// File: rtl/sstg_pkg.sv
package sstg_pkg;

  localparam int unsigned TICKS_PER_MS = 1000;
  localparam int unsigned SINE_STEPS   = 32;
  localparam int unsigned SUB_W        = $clog2(TICKS_PER_MS + 1);
  localparam int unsigned STEP_W       = $clog2(SINE_STEPS);

  // Divider geometry: 19-bit dividend, 16-bit divisor
  localparam int unsigned DVD_W     = 19;
  localparam int unsigned DVS_W     = 16;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  // Event period numerators; (1000000/f)/32 equals 31250/f
  localparam logic [DVD_W-1:0] SQUARE_NUM = DVD_W'(500000);
  localparam logic [DVD_W-1:0] SINE_NUM   = DVD_W'(1000000 / 32);

  localparam logic [9:0] HIGH_LEVEL_RST = 10'd800;
  localparam logic [9:0] REST_SINE      = 10'd512;
  localparam logic [9:0] REST_SQUARE    = 10'd0;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] note_freq;
    logic [15:0] note_duration_ms;
    logic        sine_select;
  } in_t;

  typedef struct packed {
    logic [9:0] dac_value;
    logic       note_done;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } sstg_state_e;

  function automatic logic [9:0] sine_value(input logic [STEP_W-1:0] idx);
    logic [9:0] v;
    unique case (idx)
      5'd0:  v = 10'd512;
      5'd1:  v = 10'd612;
      5'd2:  v = 10'd707;
      5'd3:  v = 10'd792;
      5'd4:  v = 10'd863;
      5'd5:  v = 10'd917;
      5'd6:  v = 10'd953;
      5'd7:  v = 10'd970;
      5'd8:  v = 10'd970;
      5'd9:  v = 10'd953;
      5'd10: v = 10'd917;
      5'd11: v = 10'd863;
      5'd12: v = 10'd792;
      5'd13: v = 10'd707;
      5'd14: v = 10'd612;
      5'd15: v = 10'd512;
      5'd16: v = 10'd412;
      5'd17: v = 10'd317;
      5'd18: v = 10'd232;
      5'd19: v = 10'd161;
      5'd20: v = 10'd107;
      5'd21: v = 10'd71;
      5'd22: v = 10'd54;
      5'd23: v = 10'd37;
      5'd24: v = 10'd37;
      5'd25: v = 10'd54;
      5'd26: v = 10'd71;
      5'd27: v = 10'd107;
      5'd28: v = 10'd161;
      5'd29: v = 10'd232;
      5'd30: v = 10'd317;
      default: v = 10'd412;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/sstg_div.sv
module sstg_div
  import sstg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;

  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

// File: rtl/square_sine_tone_generator.sv
// Square and sine tone generator for a 10-bit DAC.
// Input channel (in_valid_i/in_ready_o, in_data_i): each transfer is either a
// one microsecond tick or a start-note command (frequency, duration in ms,
// square or sine mode). Every input transfer yields exactly one result on the
// output channel (out_valid_o/out_ready_i, out_data_o): the DAC code after the
// item, a note-done flag and a busy flag.
// A tick, or a start with frequency 0, needs no divider: its result is
// registered at the accepting edge, so one such item per cycle is sustained
// while the receiver takes each result. A start with a nonzero frequency runs
// the event period through a shared restoring divider, one quotient bit per
// cycle over 19 bits; no input is taken until the divider finishes and its
// result is registered.
// The output register holds one result; while the receiver stalls with a
// result pending the block takes no new input.
// cfg_we_i/cfg_data_i write the square high level; write only while idle.
// Reset clears all tone state: DAC at 0, no note running, high level 800.
module square_sine_tone_generator
  import sstg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_data_i
);

`include "square_sine_tone_generator_defines.svh"

  sstg_state_e       state_q, state_d;

  logic [9:0]        high_level_q;
  logic [DVD_W-1:0]  half_period_q, half_period_d;
  logic [DVD_W-1:0]  period_count_q, period_count_d;
  logic [SUB_W-1:0]  sub_ms_q, sub_ms_d;
  logic [15:0]       remaining_q, remaining_d;
  logic [STEP_W-1:0] sine_step_q, sine_step_d;
  logic              square_phase_q, square_phase_d;
  logic              tone_active_q, tone_active_d;
  logic              sine_active_q, sine_active_d;
  logic [9:0]        dac_q, dac_d;
  logic              done_pend_q, done_pend_d;

  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              in_xfer;
  logic              is_start;
  logic              need_div;
  logic              div_start;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  quotient;

  logic [DVD_W:0]    pc_inc;
  logic [SUB_W:0]    sub_inc;
  logic              done_now;

  assign is_start = in_data_i.operation == OP_START;
  assign need_div = is_start && (in_data_i.note_freq != '0);
  assign in_xfer  = in_valid_i && in_ready_o;

  // Shared period divider
  sstg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.sine_select ? SINE_NUM : SQUARE_NUM),
    .divisor_i  (in_data_i.note_freq),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Sequencer: accept when idle and the output slot frees up
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_xfer && need_div) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pc_inc  = {1'b0, period_count_q} + 1'b1;
  assign sub_inc = {1'b0, sub_ms_q} + 1'b1;

  // Tone state update for ticks and starts
  always_comb begin
    half_period_d  = half_period_q;
    period_count_d = period_count_q;
    sub_ms_d       = sub_ms_q;
    remaining_d    = remaining_q;
    sine_step_d    = sine_step_q;
    square_phase_d = square_phase_q;
    tone_active_d  = tone_active_q;
    sine_active_d  = sine_active_q;
    dac_d          = dac_q;
    done_pend_d    = done_pend_q;
    done_now       = 1'b0;

    if (in_xfer && is_start) begin
      sine_active_d  = in_data_i.sine_select;
      remaining_d    = in_data_i.note_duration_ms;
      sub_ms_d       = '0;
      period_count_d = '0;
      if (need_div) begin
        square_phase_d = 1'b0;
        sine_step_d    = '0;
        tone_active_d  = 1'b1;
      end else begin
        tone_active_d = 1'b0;
        dac_d         = in_data_i.sine_select ? REST_SINE : REST_SQUARE;
      end
      if (in_data_i.note_duration_ms == '0) begin
        tone_active_d = 1'b0;
        dac_d         = in_data_i.sine_select ? REST_SINE : REST_SQUARE;
        done_now      = 1'b1;
      end
      done_pend_d = done_now;
    end else if (in_xfer) begin
      // Advance the waveform event counter
      if (tone_active_q) begin
        if (pc_inc >= {1'b0, half_period_q}) begin
          period_count_d = '0;
          if (sine_active_q) begin
            dac_d       = sine_value(sine_step_q);
            sine_step_d = sine_step_q + 1'b1;
          end else if (!square_phase_q) begin
            dac_d          = high_level_q;
            square_phase_d = 1'b1;
          end else begin
            dac_d          = REST_SQUARE;
            square_phase_d = 1'b0;
          end
        end else begin
          period_count_d = pc_inc[DVD_W-1:0];
        end
      end
      // Advance the millisecond divider and count the duration down
      if (remaining_q != '0) begin
        if (sub_inc >= (SUB_W + 1)'(TICKS_PER_MS)) begin
          sub_ms_d    = '0;
          remaining_d = remaining_q - 1'b1;
          if (remaining_q == 16'd1) begin
            tone_active_d = 1'b0;
            dac_d         = sine_active_q ? REST_SINE : REST_SQUARE;
            done_now      = 1'b1;
          end
        end else begin
          sub_ms_d = sub_inc[SUB_W-1:0];
        end
      end
    end

    // Load the event period once the divider finishes
    if (div_stat.done) begin
      half_period_d = (quotient == '0) ? DVD_W'(1) : quotient;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer && !need_div) begin
      out_valid_d     = 1'b1;
      out_d.dac_value = dac_d;
      out_d.note_done = done_now;
      out_d.busy_res  = remaining_d != '0;
    end else if (div_stat.done) begin
      out_valid_d     = 1'b1;
      out_d.dac_value = dac_q;
      out_d.note_done = done_pend_q;
      out_d.busy_res  = remaining_q != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      high_level_q   <= HIGH_LEVEL_RST;
      half_period_q  <= DVD_W'(1);
      period_count_q <= '0;
      sub_ms_q       <= '0;
      remaining_q    <= '0;
      sine_step_q    <= '0;
      square_phase_q <= 1'b0;
      tone_active_q  <= 1'b0;
      sine_active_q  <= 1'b0;
      dac_q          <= '0;
      done_pend_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (cfg_we_i) begin
        high_level_q <= cfg_data_i;
      end
      half_period_q  <= half_period_d;
      period_count_q <= period_count_d;
      sub_ms_q       <= sub_ms_d;
      remaining_q    <= remaining_d;
      sine_step_q    <= sine_step_d;
      square_phase_q <= square_phase_d;
      tone_active_q  <= tone_active_d;
      sine_active_q  <= sine_active_d;
      dac_q          <= dac_d;
      done_pend_q    <= done_pend_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SSTG_ASSERT(a_no_accept_in_div, clk_i, rst_ni, (state_q == ST_DIV) |-> !in_ready_o)
  `SSTG_ASSERT(a_done_only_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == ST_DIV))
  `SSTG_ASSERT(a_div_slot_free, clk_i, rst_ni, (state_q == ST_DIV) |-> !out_valid_q)
  `SSTG_ASSERT_ALWAYS(a_period_nonzero, clk_i, !rst_ni || (half_period_q != '0))

endmodule
